>>> rtl/core/hnf_pkg.sv
// Shared types, character codes and letter tables for the Hebrew numeral formatter.
package hnf_pkg;

    // Default cap on the input value; larger values are saturated to it.
    localparam int unsigned MaxValueDef = 16383;

    // Field widths.
    localparam int unsigned ValueW = 14;
    localparam int unsigned CodeW  = 16;

    // Arithmetic constants.
    localparam logic [ValueW-1:0] TavStep = 14'd400;

    // Character codes.
    localparam logic [CodeW-1:0] CodeNone       = 16'h0000;
    localparam logic [CodeW-1:0] CodeTav        = 16'h05EA;
    localparam logic [CodeW-1:0] CodeTet        = 16'h05D8;
    localparam logic [CodeW-1:0] CodeVav        = 16'h05D5;
    localparam logic [CodeW-1:0] CodeZayin      = 16'h05D6;
    localparam logic [CodeW-1:0] CodeGeresh     = 16'h0027;
    localparam logic [CodeW-1:0] CodeGershayim  = 16'h0022;

    // Letter tables: hundreds (qof..tav), tens (yod..tsadi), ones (alef..tet).
    localparam logic [CodeW-1:0] HundredsCodes [4] = '{
        16'h05E7, 16'h05E8, 16'h05E9, 16'h05EA
    };
    localparam logic [CodeW-1:0] TensCodes [9] = '{
        16'h05D9, 16'h05DB, 16'h05DC, 16'h05DE, 16'h05E0,
        16'h05E1, 16'h05E2, 16'h05E4, 16'h05E6
    };
    localparam logic [CodeW-1:0] OnesCodes [9] = '{
        16'h05D0, 16'h05D1, 16'h05D2, 16'h05D3, 16'h05D4,
        16'h05D5, 16'h05D6, 16'h05D7, 16'h05D8
    };

    // Input word.
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              add_quotes;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [CodeW-1:0] char_code;
        logic             last;
        logic             empty_res;
    } out_word_t;

    // Which character the datapath registers for the output word.
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_EMPTY,
        EMIT_TAV,
        EMIT_HEAD,
        EMIT_GERSH,
        EMIT_TAIL
    } emit_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      decomp;
        emit_sel_t emit_sel;
        logic      last;
        logic      tail_geresh;
    } hnf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_zero;
        logic over_400;
        logic cnt_one;
        logic quotes;
        logic any_out;
    } hnf_status_t;

endpackage

>>> rtl/core/hnf_datapath.sv
// Datapath: value register, tav countdown, letter queue and output word register.
module hnf_datapath #(
    parameter int unsigned MAX_VALUE = hnf_pkg::MaxValueDef
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hnf_pkg::in_word_t   in_word,
    input  hnf_pkg::hnf_cmd_t   cmd,
    output hnf_pkg::hnf_status_t status,
    output logic                out_strobe,
    output hnf_pkg::out_word_t  out_word
);
    import hnf_pkg::*;

    localparam logic [ValueW-1:0] MaxVal = ValueW'(MAX_VALUE);

    logic [ValueW-1:0] num_reg;
    logic              quotes_reg;
    logic              any_reg;
    logic [CodeW-1:0]  q_reg [3];
    logic [1:0]        cnt_reg;
    logic [CodeW-1:0]  tail_reg;
    logic              out_strobe_reg;
    out_word_t         out_word_reg;

    logic [ValueW-1:0] value_sat;
    logic [8:0]        rem_400;
    logic [2:0]        hund;
    logic [6:0]        rem_100;
    logic [3:0]        tens;
    logic [3:0]        ones;
    logic [CodeW-1:0]  lst [3];
    logic [1:0]        lst_cnt;
    out_word_t         word_next;

    // Saturate the incoming value.
    assign value_sat = (in_word.value > MaxVal) ? MaxVal : in_word.value;

    // Split the remainder (at most 400) into hundreds, tens and ones.
    assign rem_400 = num_reg[8:0];

    always_comb
    begin
        if (rem_400 >= 9'd400)
            hund = 3'd4;
        else if (rem_400 >= 9'd300)
            hund = 3'd3;
        else if (rem_400 >= 9'd200)
            hund = 3'd2;
        else if (rem_400 >= 9'd100)
            hund = 3'd1;
        else
            hund = 3'd0;
    end

    always_comb
    begin
        case (hund)
            3'd4:    rem_100 = 7'(rem_400 - 9'd400);
            3'd3:    rem_100 = 7'(rem_400 - 9'd300);
            3'd2:    rem_100 = 7'(rem_400 - 9'd200);
            3'd1:    rem_100 = 7'(rem_400 - 9'd100);
            default: rem_100 = rem_400[6:0];
        endcase
    end

    // Tens digit by a compare chain; ones digit from the matching offset.
    always_comb
    begin
        if (rem_100 >= 7'd90)
            tens = 4'd9;
        else if (rem_100 >= 7'd80)
            tens = 4'd8;
        else if (rem_100 >= 7'd70)
            tens = 4'd7;
        else if (rem_100 >= 7'd60)
            tens = 4'd6;
        else if (rem_100 >= 7'd50)
            tens = 4'd5;
        else if (rem_100 >= 7'd40)
            tens = 4'd4;
        else if (rem_100 >= 7'd30)
            tens = 4'd3;
        else if (rem_100 >= 7'd20)
            tens = 4'd2;
        else if (rem_100 >= 7'd10)
            tens = 4'd1;
        else
            tens = 4'd0;
        ones = 4'(rem_100 - 7'(tens) * 7'd10);
    end

    // Assemble the letter list in reading order; fifteen and sixteen use tet first.
    always_comb
    begin
        lst[0]  = CodeNone;
        lst[1]  = CodeNone;
        lst[2]  = CodeNone;
        lst_cnt = 2'd0;
        if (hund != 3'd0)
        begin
            lst[lst_cnt] = HundredsCodes[2'(hund - 3'd1)];
            lst_cnt      = lst_cnt + 2'd1;
        end
        if (rem_100 == 7'd15 || rem_100 == 7'd16)
        begin
            lst[lst_cnt] = CodeTet;
            lst_cnt      = lst_cnt + 2'd1;
            lst[lst_cnt] = (rem_100 == 7'd15) ? CodeVav : CodeZayin;
            lst_cnt      = lst_cnt + 2'd1;
        end
        else
        begin
            if (tens != 4'd0)
            begin
                lst[lst_cnt] = TensCodes[4'(tens - 4'd1)];
                lst_cnt      = lst_cnt + 2'd1;
            end
            if (ones != 4'd0)
            begin
                lst[lst_cnt] = OnesCodes[4'(ones - 4'd1)];
                lst_cnt      = lst_cnt + 2'd1;
            end
        end
    end

    // Output word selection.
    always_comb
    begin
        word_next.char_code = CodeNone;
        word_next.last      = cmd.last;
        word_next.empty_res = 1'b0;
        unique case (cmd.emit_sel)
            EMIT_EMPTY:
            begin
                word_next.empty_res = 1'b1;
            end
            EMIT_TAV:   word_next.char_code = CodeTav;
            EMIT_HEAD:  word_next.char_code = q_reg[0];
            EMIT_GERSH: word_next.char_code = CodeGershayim;
            EMIT_TAIL:  word_next.char_code = tail_reg;
            default:    word_next.char_code = CodeNone;
        endcase
    end

    // Control flags and output strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_strobe_reg <= 1'b0;
            cnt_reg        <= 2'd0;
            any_reg        <= 1'b0;
        end
        else
        begin
            out_strobe_reg <= (cmd.emit_sel != EMIT_NONE);
            if (cmd.load)
                any_reg <= 1'b0;
            else if (cmd.emit_sel != EMIT_NONE)
                any_reg <= 1'b1;
            if (cmd.decomp)
                cnt_reg <= lst_cnt;
            else if (cmd.emit_sel == EMIT_HEAD || cmd.emit_sel == EMIT_GERSH)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_word_reg <= word_next;
        if (cmd.load)
        begin
            num_reg    <= value_sat;
            quotes_reg <= in_word.add_quotes;
        end
        else if (cmd.emit_sel == EMIT_TAV)
        begin
            num_reg <= ValueW'(num_reg - TavStep);
        end
        if (cmd.decomp)
        begin
            q_reg[0] <= lst[0];
            q_reg[1] <= lst[1];
            q_reg[2] <= lst[2];
        end
        else if (cmd.emit_sel == EMIT_HEAD)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
        if (cmd.emit_sel == EMIT_GERSH)
            tail_reg <= q_reg[0];
        else if (cmd.emit_sel == EMIT_HEAD && cmd.tail_geresh)
            tail_reg <= CodeGeresh;
    end

    assign status.is_zero  = (num_reg == '0);
    assign status.over_400 = (num_reg > TavStep);
    assign status.cnt_one  = (cnt_reg == 2'd1);
    assign status.quotes   = quotes_reg;
    assign status.any_out  = any_reg;

    assign out_strobe = out_strobe_reg;
    assign out_word   = out_word_reg;

`ifndef ASSERT_OFF
    a_decomp_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decomp |=> cnt_reg != 2'd0)
        else $error("letter queue empty after decomposition");
    a_tav_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sel == EMIT_TAV |-> num_reg > TavStep)
        else $error("tav emitted with value not above 400");
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sel == EMIT_HEAD || cmd.emit_sel == EMIT_GERSH) |-> cnt_reg != 2'd0)
        else $error("letter popped from an empty queue");
`endif

endmodule

>>> rtl/core/hnf_ctrl.sv
// Controller state machine that sequences tav, letter and punctuation characters.
module hnf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  hnf_pkg::hnf_status_t status,
    output hnf_pkg::hnf_cmd_t    cmd,
    output logic                 busy
);
    import hnf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAV,
        S_LETTERS,
        S_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd.load        = 1'b0;
        cmd.decomp      = 1'b0;
        cmd.emit_sel    = EMIT_NONE;
        cmd.last        = 1'b0;
        cmd.tail_geresh = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TAV;
                end
            end
            S_TAV:
            begin
                if (status.is_zero)
                begin
                    cmd.emit_sel = EMIT_EMPTY;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (status.over_400)
                begin
                    cmd.emit_sel = EMIT_TAV;
                end
                else
                begin
                    cmd.decomp = 1'b1;
                    state_next = S_LETTERS;
                end
            end
            S_LETTERS:
            begin
                if (!status.cnt_one)
                begin
                    cmd.emit_sel = EMIT_HEAD;
                end
                else if (status.quotes && status.any_out)
                begin
                    // Longer run: double quote goes in before the final letter.
                    cmd.emit_sel = EMIT_GERSH;
                    state_next   = S_TAIL;
                end
                else if (status.quotes)
                begin
                    // Single letter: apostrophe follows it.
                    cmd.emit_sel    = EMIT_HEAD;
                    cmd.tail_geresh = 1'b1;
                    state_next      = S_TAIL;
                end
                else
                begin
                    cmd.emit_sel = EMIT_HEAD;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TAIL:
            begin
                cmd.emit_sel = EMIT_TAIL;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

`ifndef ASSERT_OFF
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == S_TAV)
        else $error("accepted word did not start formatting");
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(cmd.last))
        else $error("controller went idle without a final character");
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |-> (cmd.emit_sel != EMIT_NONE && state_next == S_IDLE))
        else $error("final flag without an emitted character");
`endif

endmodule

>>> rtl/core/hebrew_numeral_formatter.sv
// Top level of the Hebrew numeral formatter: controller plus datapath.
//
// Usage: drive in_word (value, add_quotes) and raise start; the word is
// accepted at a rising edge where start is high and busy is low.
// The block then emits the numeral one character per output word on
// out_word, each valid for exactly one cycle while out_strobe is high;
// out_word.last marks the final character. A zero value gives one word
// with empty_res and last set. Values above MAX_VALUE are saturated.
// Order: when the value is zero or above 400 the first character (tav or
// empty word) is registered from state S_TAV; otherwise S_TAV first does
// the letter split and the first letter is registered from S_LETTERS.
// A word gives T tav repeats (up to 40), then k letters (1 to 3), and
// one punctuation mark when quotes are added; a zero value gives only
// the empty word. The controller emits one character per cycle, except
// in the letter-split step.
// The final character is strobed in the same cycle that busy falls.
// The receiver cannot stall; every strobe must be taken.
// Reset clears the controller and the output strobe; no words are pending.
module hebrew_numeral_formatter #(
    parameter int unsigned MAX_VALUE = hnf_pkg::MaxValueDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hnf_pkg::in_word_t  in_word,
    output logic               out_strobe,
    output hnf_pkg::out_word_t out_word
);
    import hnf_pkg::*;

    hnf_cmd_t    cmd;
    hnf_status_t status;

    // Sequencing controller.
    hnf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Value, letter queue and output register.
    hnf_datapath #(
        .MAX_VALUE (MAX_VALUE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_word    (in_word),
        .cmd        (cmd),
        .status     (status),
        .out_strobe (out_strobe),
        .out_word   (out_word)
    );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the Hebrew numeral formatter block.
`timescale 1ns / 1ps

module tb_top;

    import hnf_pkg::*;

    // Run limits and the pause used before the final verdict.
    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned DrainCycles = 4;
    localparam int unsigned MaxValue = MaxValueDef;

    // Letter codes used by the numeral predictor.
    localparam logic [15:0] LetterTav = 16'h05EA;
    localparam logic [15:0] MarkGeresh = 16'h0027;
    localparam logic [15:0] MarkGershayim = 16'h0022;
    localparam logic [3:0][15:0] HundredLetters = {
        16'h05EA, 16'h05E9, 16'h05E8, 16'h05E7
    };
    localparam logic [8:0][15:0] TenLetters = {
        16'h05E6, 16'h05E4, 16'h05E2, 16'h05E1, 16'h05E0,
        16'h05DE, 16'h05DC, 16'h05DB, 16'h05D9
    };
    localparam logic [8:0][15:0] OneLetters = {
        16'h05D8, 16'h05D7, 16'h05D6, 16'h05D5, 16'h05D4,
        16'h05D3, 16'h05D2, 16'h05D1, 16'h05D0
    };

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_word_t   in_word;
    logic       out_strobe;
    out_word_t  out_word;

    // Characters still owed by the block, oldest first.
    out_word_t  pending_chars[$];

    int unsigned error_count;
    int unsigned cycle_count = 0;
    int unsigned chars_checked;
    int unsigned words_sent;
    int unsigned zero_words;
    int unsigned quoted_words;
    int unsigned long_runs;
    int unsigned burst_left;

    hebrew_numeral_formatter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_word    (in_word),
        .out_strobe (out_strobe),
        .out_word   (out_word)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("[hebrew_numeral_formatter] ERROR");
            $finish;
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch: %s expected 0x%0h got 0x%0h (char %0d)",
                 what, want, got, chars_checked);
        error_count++;
    endtask

    // Appends one owed character at the back of the queue.
    function automatic void owe_char(input out_word_t w);
        pending_chars = {pending_chars, w};
    endfunction

    // Works out the character run for one word and queues it.
    function automatic void predict_numeral(input logic [13:0] value, input logic quotes);
        logic [15:0] run [48];
        int          len;
        int unsigned n;
        int unsigned hundreds;
        int unsigned tens;
        out_word_t   w;
        len = 0;
        n = value;
        if (n > MaxValue)
            n = MaxValue;
        // Zero has no letters: one empty marker, never punctuated.
        if (n == 0)
        begin
            w.char_code = 16'h0000;
            w.last = 1'b1;
            w.empty_res = 1'b1;
            owe_char(w);
            return;
        end
        while (n > 400 && len < 44)
        begin
            run[len] = LetterTav;
            len++;
            n -= 400;
        end
        hundreds = n / 100;
        n = n % 100;
        if (hundreds > 0 && hundreds <= 4)
        begin
            run[len] = HundredLetters[hundreds - 1];
            len++;
        end
        // Fifteen and sixteen are spelled tet-vav and tet-zayin.
        if (n == 16 || n == 15)
        begin
            run[len] = OneLetters[8];
            run[len + 1] = (n == 16) ? OneLetters[6] : OneLetters[5];
            len += 2;
        end
        else
        begin
            tens = n / 10;
            n = n % 10;
            if (tens > 0)
            begin
                run[len] = TenLetters[tens - 1];
                len++;
            end
            if (n > 0)
            begin
                run[len] = OneLetters[n - 1];
                len++;
            end
        end
        // A lone letter takes a trailing geresh; longer runs get gershayim before the end.
        if (quotes)
        begin
            if (len == 1)
            begin
                run[len] = MarkGeresh;
            end
            else
            begin
                run[len] = run[len - 1];
                run[len - 1] = MarkGershayim;
            end
            len++;
        end
        for (int k = 0; k < len; k++)
        begin
            w.char_code = run[k];
            w.last = (k == len - 1);
            w.empty_res = 1'b0;
            owe_char(w);
        end
    endfunction

    // Compares each strobed character with the oldest one owed.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                report_mismatch("unexpected char_code", 0, out_word.char_code);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_word.char_code !== want.char_code)
                    report_mismatch("char_code", want.char_code, out_word.char_code);
                if (out_word.last !== want.last)
                    report_mismatch("last", want.last, out_word.last);
                if (out_word.empty_res !== want.empty_res)
                    report_mismatch("empty_res", want.empty_res, out_word.empty_res);
            end
            chars_checked++;
        end
    end

    // Offers one word and returns at the edge that accepts it; start stays high.
    task automatic send_word(input logic [13:0] value, input logic quotes);
        start <= 1'b1;
        in_word <= '{value: value, add_quotes: quotes};
        do
            @(posedge clk);
        while (busy);
        predict_numeral(value, quotes);
        words_sent++;
        if (value == 0)
            zero_words++;
        if (quotes)
            quoted_words++;
        if (value >= 16000)
            long_runs++;
    endtask

    // Lowers start and lets the given number of cycles pass.
    task automatic idle_cycles(input int unsigned n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sends one word inside the burst pattern: random burst lengths, random gaps.
    task automatic push_word(input logic [13:0] value, input logic quotes);
        send_word(value, quotes);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            idle_cycles($urandom_range(1, 7));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // Waits until every owed character has come out.
    task automatic wait_drained();
        idle_cycles(1);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Field extremes: zero, one and the largest value, with and without quotes, plus 8192 quoted.
    task automatic test_extremes();
        push_word(14'd0, 1'b0);
        push_word(14'd0, 1'b1);
        push_word(14'd1, 1'b0);
        push_word(14'd1, 1'b1);
        push_word(14'd16383, 1'b0);
        push_word(14'd16383, 1'b1);
        push_word(14'd8192, 1'b1);
    endtask

    // Fifteen, sixteen, tav boundaries and single-letter geresh cases.
    task automatic test_special_spellings();
        push_word(14'd15, 1'b1);
        push_word(14'd16, 1'b1);
        push_word(14'd15, 1'b0);
        push_word(14'd16, 1'b0);
        push_word(14'd115, 1'b1);
        push_word(14'd416, 1'b1);
        push_word(14'd400, 1'b1);
        push_word(14'd401, 1'b1);
        push_word(14'd800, 1'b0);
        push_word(14'd10, 1'b1);
        push_word(14'd99, 1'b1);
        push_word(14'd499, 1'b0);
    endtask

    // The sender holds off until the block has delivered everything, then resumes.
    task automatic test_drain_pause();
        push_word(14'd1234, 1'b1);
        push_word(14'd7, 1'b0);
        wait_drained();
        send_word(14'd300, 1'b1);
        send_word(14'd12000, 1'b0);
        idle_cycles(1);
    endtask

    // Random words, weighted toward short runs with some long tav chains.
    task automatic test_random_words(input int unsigned count);
        logic [13:0] value;
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:
                begin
                    case ($urandom_range(0, 5))
                        0: value = 14'd0;
                        1: value = 14'd15;
                        2: value = 14'd16;
                        3: value = 14'(100 * $urandom_range(0, 160) + 15);
                        4: value = 14'(100 * $urandom_range(0, 160) + 16);
                        default: value = 14'(400 * $urandom_range(1, 40));
                    endcase
                end
                1, 2, 9: value = 14'($urandom_range(0, 16383));
                3, 4, 5: value = 14'($urandom_range(1, 99));
                6, 7: value = 14'($urandom_range(100, 499));
                default: value = 14'(400 * $urandom_range(1, 40) + $urandom_range(0, 20));
            endcase
            push_word(value, 1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        error_count = 0;
        chars_checked = 0;
        words_sent = 0;
        zero_words = 0;
        quoted_words = 0;
        long_runs = 0;
        burst_left = $urandom_range(1, 6);
        rst_n <= 1'b0;
        start <= 1'b0;
        in_word <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_special_spellings();
        test_drain_pause();
        test_random_words(107);

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d words: %0d zero, %0d quoted, %0d with long tav chains.",
                 words_sent, zero_words, quoted_words, long_runs);
        $display("Checked %0d output characters field by field.", chars_checked);
        if (error_count == 0)
        begin
            $display("[hebrew_numeral_formatter] OK");
        end
        else
        begin
            $display("[hebrew_numeral_formatter] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/hnf_pkg.sv
rtl/core/hnf_datapath.sv
rtl/core/hnf_ctrl.sv
rtl/core/hebrew_numeral_formatter.sv
dv/tb_top.sv
